@@ sv/rrs_pkg.sv @@
// Shared types, constants and helper functions of the repeat run suppressor.
`default_nettype none

package rrs_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CountWidth = (COUNT_BITS > 16) ? 16 : COUNT_BITS;
  localparam logic [CountWidth-1:0] CountMax = '1;

  localparam int CntDigits = 5;
  localparam int ValDigits = 3;

  localparam logic [7:0] NewlineByte = 8'd10;
  localparam logic [7:0] KeepLimitReset = 8'd10;
  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] OpenBracket = 8'h5B;
  localparam logic [7:0] CloseBracket = 8'h5D;
  localparam logic [7:0] AsciiSpace = 8'h20;

  localparam logic [2:0] MoreLen = 3'd6;
  localparam logic [2:0] BytesLen = 3'd7;

  typedef logic [3:0] bcd_t;
  typedef bcd_t [CntDigits-1:0] cnt_bcd_t;
  typedef bcd_t [ValDigits-1:0] val_bcd_t;

  typedef struct packed {
    logic       marker;
    logic [7:0] data;
    cnt_bcd_t   cnt_digits;
    logic [2:0] cnt_len;
    val_bcd_t   val_digits;
    logic [1:0] val_len;
  } job_t;

  function automatic cnt_bcd_t bcd_inc(input cnt_bcd_t d);
    cnt_bcd_t r;
    logic     carry;
    r = d;
    carry = 1'b1;
    for (int i = 0; i < CntDigits; i++) begin
      if (carry) begin
        if (d[i] == 4'd9) begin
          r[i] = 4'd0;
        end else begin
          r[i] = d[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] cnt_length(input cnt_bcd_t d);
    logic [2:0] len;
    len = 3'd1;
    for (int i = 1; i < CntDigits; i++) begin
      if (d[i] != 4'd0) begin
        len = 3'(i + 1);
      end
    end
    return len;
  endfunction

  function automatic val_bcd_t byte_to_bcd(input logic [7:0] v);
    logic [19:0] sr;
    sr = {12'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (sr[11:8] >= 4'd5) sr[11:8] = sr[11:8] + 4'd3;
      if (sr[15:12] >= 4'd5) sr[15:12] = sr[15:12] + 4'd3;
      if (sr[19:16] >= 4'd5) sr[19:16] = sr[19:16] + 4'd3;
      sr = sr << 1;
    end
    return sr[19:8];
  endfunction

  function automatic logic [1:0] val_length(input logic [7:0] v);
    logic [1:0] len;
    if (v >= 8'd100) begin
      len = 2'd3;
    end else if (v >= 8'd10) begin
      len = 2'd2;
    end else begin
      len = 2'd1;
    end
    return len;
  endfunction

  function automatic logic [7:0] digit_char(input bcd_t d);
    return AsciiZero | {4'd0, d};
  endfunction

  function automatic logic [7:0] more_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd1: c = 8'h6D;
      3'd2: c = 8'h6F;
      3'd3: c = 8'h72;
      3'd4: c = 8'h65;
      default: c = AsciiSpace;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] bytes_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd1: c = 8'h62;
      3'd2: c = 8'h79;
      3'd3: c = 8'h74;
      3'd4: c = 8'h65;
      3'd5: c = 8'h73;
      3'd6: c = CloseBracket;
      default: c = AsciiSpace;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/rrs_tracker.sv @@
// Run tracking, drop counting and per-byte job decision.
`default_nettype none

module rrs_tracker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    in_byte,
  input  wire logic          accept,
  input  wire logic          cfg_valid,
  input  wire logic [7:0]    cfg_limit,
  output rrs_pkg::job_t      job,
  output logic               job_valid
);
  import rrs_pkg::*;

  logic [7:0]            keep_limit;
  logic [7:0]            previous_byte;
  logic                  previous_valid;
  logic [7:0]            run_length;
  logic                  suppressing;
  logic [CountWidth-1:0] dropped_count;
  cnt_bcd_t              count_bcd;

  logic repeat_hit;
  logic keep;

  always_comb begin
    repeat_hit = previous_valid && (in_byte == previous_byte);
    keep = run_length < keep_limit;
    job_valid = !repeat_hit || keep;
    job.marker = !repeat_hit && suppressing && (dropped_count != '0);
    job.data = in_byte;
    job.cnt_digits = count_bcd;
    job.cnt_len = cnt_length(count_bcd);
    job.val_digits = byte_to_bcd(previous_byte);
    job.val_len = val_length(previous_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_limit <= KeepLimitReset;
      previous_byte <= '0;
      previous_valid <= 1'b0;
      run_length <= '0;
      suppressing <= 1'b0;
      dropped_count <= '0;
      count_bcd <= '0;
    end else begin
      if (cfg_valid) begin
        keep_limit <= cfg_limit;
      end
      if (accept) begin
        if (in_byte == NewlineByte) begin
          previous_byte <= '0;
          previous_valid <= 1'b0;
          run_length <= '0;
          suppressing <= 1'b0;
          dropped_count <= '0;
          count_bcd <= '0;
        end else if (repeat_hit) begin
          if (keep) begin
            run_length <= run_length + 8'd1;
          end else begin
            suppressing <= 1'b1;
            if (dropped_count != CountMax) begin
              dropped_count <= dropped_count + CountWidth'(1);
              count_bcd <= bcd_inc(count_bcd);
            end
          end
        end else begin
          previous_byte <= in_byte;
          previous_valid <= 1'b1;
          run_length <= 8'd1;
          suppressing <= 1'b0;
          dropped_count <= '0;
          count_bcd <= '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/rrs_emitter.sv @@
// Marker and byte sequencer with the registered output beat.
`default_nettype none

module rrs_emitter (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rrs_pkg::job_t job,
  input  wire logic          job_valid,
  input  wire logic          accept,
  output logic               job_ready,
  input  wire logic          out_stall,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic               last_of_run
);
  import rrs_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPEN,
    PH_COUNT,
    PH_MORE,
    PH_VAL,
    PH_BYTES,
    PH_BYTE
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [2:0] idx;
  logic [2:0] idx_next;
  job_t       cur;
  logic [7:0] char_sel;
  logic       out_load;

  assign out_load = !out_valid || !out_stall;
  assign job_ready = (phase == PH_IDLE) || ((phase == PH_BYTE) && out_load);

  always_comb begin
    char_sel = cur.data;
    phase_next = PH_IDLE;
    idx_next = idx;
    case (phase)
      PH_OPEN: begin
        char_sel = OpenBracket;
        phase_next = PH_COUNT;
        idx_next = cur.cnt_len - 3'd1;
      end
      PH_COUNT: begin
        char_sel = digit_char(cur.cnt_digits[idx]);
        if (idx == 3'd0) begin
          phase_next = PH_MORE;
        end else begin
          phase_next = PH_COUNT;
          idx_next = idx - 3'd1;
        end
      end
      PH_MORE: begin
        char_sel = more_char(idx);
        if (idx == MoreLen - 3'd1) begin
          phase_next = PH_VAL;
          idx_next = {1'b0, cur.val_len} - 3'd1;
        end else begin
          phase_next = PH_MORE;
          idx_next = idx + 3'd1;
        end
      end
      PH_VAL: begin
        char_sel = digit_char(cur.val_digits[idx[1:0]]);
        if (idx == 3'd0) begin
          phase_next = PH_BYTES;
        end else begin
          phase_next = PH_VAL;
          idx_next = idx - 3'd1;
        end
      end
      PH_BYTES: begin
        char_sel = bytes_char(idx);
        if (idx == BytesLen - 3'd1) begin
          phase_next = PH_BYTE;
        end else begin
          phase_next = PH_BYTES;
          idx_next = idx + 3'd1;
        end
      end
      PH_BYTE: begin
        char_sel = cur.data;
        phase_next = PH_IDLE;
      end
      default: begin
        char_sel = cur.data;
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((phase != PH_IDLE) && out_load) begin
        out_byte <= char_sel;
        last_of_run <= (phase == PH_BYTE);
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept && job_valid) begin
        cur <= job;
        phase <= job.marker ? PH_OPEN : PH_BYTE;
        idx <= '0;
      end else if ((phase != PH_IDLE) && out_load) begin
        phase <= phase_next;
        idx <= idx_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/repeat_run_suppressor_unit.sv @@
// Top level of the repeat run suppressor: byte in, passed bytes and markers out.
//
//   channel  signals                          direction  beat
//   in       in_valid, in_stall, in_byte      input      one stream byte
//   out      out_valid, out_stall, out_byte,  output     one output character
//            last_of_run
//   cfg      cfg_valid, cfg_ready,            input      run keep limit write
//            run_keep_limit
//
// A byte that passes yields one output character and a dropped byte none; a
// byte that flushes a marker yields the marker characters and then itself (up
// to 23 characters), sent through the single output register of the sequencer.
// Reset is synchronous; the keep limit returns to 10 and run tracking clears.
// out_stall holds the output beat and, once the sequencer has a job waiting,
// raises in_stall; a new byte is taken in the cycle its predecessor's last
// beat is loaded.
`default_nettype none

module repeat_run_suppressor_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            last_of_run,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] run_keep_limit
);
  import rrs_pkg::*;

  job_t job;
  logic job_valid;
  logic job_ready;
  logic accept;

  assign in_stall = !job_ready;
  assign accept = in_valid && job_ready;
  assign cfg_ready = 1'b1;

  rrs_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_byte),
    .accept    (accept),
    .cfg_valid (cfg_valid),
    .cfg_limit (run_keep_limit),
    .job       (job),
    .job_valid (job_valid)
  );

  rrs_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .job         (job),
    .job_valid   (job_valid),
    .accept      (accept),
    .job_ready   (job_ready),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire
